FILE: rtl/mandelbrot_escape_time_core_assert.svh
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MET_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/met_pkg.sv
package met_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 28;
	localparam int Q_BITS     = FRAC_BITS + 4;
	localparam int DIM_BITS   = 13;
	localparam int ITER_BITS  = 16;
	localparam int INT_BITS   = 16;

	// |2*(2p - d)| fits in MAG_BITS
	localparam int MAG_BITS = (COORD_BITS + 2 > DIM_BITS + 1) ? COORD_BITS + 2 : DIM_BITS + 1;
	localparam int DVD_BITS = (MAG_BITS + FRAC_BITS > ITER_BITS + INT_BITS) ?
		MAG_BITS + FRAC_BITS : ITER_BITS + INT_BITS;
	localparam int DVS_BITS  = (ITER_BITS > DIM_BITS) ? ITER_BITS : DIM_BITS;
	localparam int DCNT_BITS = $clog2(DVD_BITS + 1);
	localparam int PROD_BITS = 2 * Q_BITS;
	localparam int TRN_BITS  = PROD_BITS - FRAC_BITS;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER     = CFG_IDX_BITS'(2);

	typedef logic signed [Q_BITS-1:0] q_t;

	localparam q_t Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
	localparam q_t Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		logic                  plotted;
		logic [ITER_BITS-1:0]  escape_count;
		logic [INT_BITS-1:0]   intensity;
	} pix_out_t;

	typedef struct packed {
		logic                start;
		logic [DVD_BITS-1:0] dividend;
		logic [DVS_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [DVD_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/met_div.sv
module met_div import met_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DCNT_BITS-1:0] cnt_q;
	logic                 done_q;
	logic [DVD_BITS-1:0]  dq_q;
	logic [DVS_BITS-1:0]  rem_q;
	logic [DVS_BITS-1:0]  dvs_q;

	logic [DVS_BITS:0] trial;
	logic [DVS_BITS:0] diff;
	logic              ge;

	// restoring division, one quotient bit per cycle; quotient shifts in behind dividend
	assign trial = {rem_q, dq_q[DVD_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= DCNT_BITS'(DVD_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DCNT_BITS'(1);
			done_q <= (cnt_q == DCNT_BITS'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[DVD_BITS-2:0], ge};
			rem_q <= ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
		end
	end

	assign rsp.busy     = (cnt_q != '0);
	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

FILE: rtl/met_zsq.sv
module met_zsq import met_pkg::*; (
	input  logic clk,
	input  q_t   zx,
	input  q_t   zy,
	output q_t   sx,
	output q_t   sy,
	output q_t   xy
);

	logic signed [PROD_BITS-1:0] pxx_s1;
	logic signed [PROD_BITS-1:0] pyy_s1;
	logic signed [PROD_BITS-1:0] pxy_s1;
	q_t                          sx_s2;
	q_t                          sy_s2;
	q_t                          xy_s2;

	// drop FRAC_BITS toward zero, then clamp to Q4 range
	function automatic q_t trunc_sat(input logic signed [PROD_BITS-1:0] p);
		logic signed [TRN_BITS-1:0] t;
		t = p[PROD_BITS-1:FRAC_BITS];
		if (p[PROD_BITS-1] && (|p[FRAC_BITS-1:0]))
			t = t + TRN_BITS'(1);
		if (t[TRN_BITS-1:Q_BITS-1] == '0 || t[TRN_BITS-1:Q_BITS-1] == '1)
			return t[Q_BITS-1:0];
		return t[TRN_BITS-1] ? Q_MIN : Q_MAX;
	endfunction

	always_ff @(posedge clk) begin
		pxx_s1 <= zx * zx;
		pyy_s1 <= zy * zy;
		pxy_s1 <= zx * zy;
		sx_s2  <= trunc_sat(pxx_s1);
		sy_s2  <= trunc_sat(pyy_s1);
		xy_s2  <= trunc_sat(pxy_s1);
	end

	assign sx = sx_s2;
	assign sy = sy_s2;
	assign xy = xy_s2;

endmodule

FILE: rtl/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core: one pixel in, one result out. The pixel is mapped to c in signed
// Q4.28 by a shared radix-2 divider, x axis then y axis, then z = z*z + c iterates on a
// two-stage complex-square unit, and a plotted pixel takes one more divider pass for its
// intensity. The default iteration limit is 256. in_ready is high only between pixels; a
// finished result sits in the output register, so the next pixel can start while it waits.
`include "mandelbrot_escape_time_core_assert.svh"

module mandelbrot_escape_time_core import met_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pix_in_t                  in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pix_out_t                 out_data
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIVX = 8'b0000_0010,
		ST_DIVY = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_TRN  = 8'b0001_0000,
		ST_UPD  = 8'b0010_0000,
		ST_DIVI = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	localparam logic [Q_BITS-1:0] ESC_LIMIT = Q_BITS'(4) << FRAC_BITS;

	state_t               state_q, state_d;
	logic [DIM_BITS-1:0]  img_w_q;
	logic [DIM_BITS-1:0]  img_h_q;
	logic [ITER_BITS-1:0] max_iter_q;
	logic                 out_valid_q;
	pix_out_t             out_q;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic                  neg_q;
	q_t                    cx_q, cy_q, zx_q, zy_q;
	logic [ITER_BITS-1:0]  count_q;
	logic                  hit_q;
	logic [INT_BITS-1:0]   int_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	q_t       sx, sy, xy;

	logic [DIM_BITS-1:0]   w_eff;
	logic [MAG_BITS:0]     num_x, num_y;
	logic [Q_BITS-1:0]     esc_sum;
	logic signed [Q_BITS+1:0] re_sum, im_sum;
	logic                  in_fire, upd_stop, upd_hit, out_load;
	q_t                    c_new;

	// 2*(2p - d) in two's complement
	function automatic logic [MAG_BITS:0] coord_num(input logic [COORD_BITS-1:0] p,
			input logic [DIM_BITS-1:0] d);
		logic [MAG_BITS:0] a;
		logic [MAG_BITS:0] b;
		a = (MAG_BITS+1)'({p, 2'b00});
		b = (MAG_BITS+1)'({d, 1'b0});
		return a - b;
	endfunction

	function automatic logic [DVD_BITS-1:0] coord_dvd(input logic [MAG_BITS:0] num);
		logic [MAG_BITS:0] m;
		m = num[MAG_BITS] ? -num : num;
		return DVD_BITS'({m[MAG_BITS-1:0], {FRAC_BITS{1'b0}}});
	endfunction

	function automatic q_t quo_to_q(input logic [DVD_BITS-1:0] quo, input logic neg);
		q_t m;
		m = q_t'({1'b0, quo[Q_BITS-2:0]});
		if (|quo[DVD_BITS-1:Q_BITS-1])
			return neg ? Q_MIN : Q_MAX;
		return neg ? -m : m;
	endfunction

	function automatic q_t sat_sum(input logic signed [Q_BITS+1:0] v);
		if (v[Q_BITS+1:Q_BITS-1] == '0 || v[Q_BITS+1:Q_BITS-1] == '1)
			return v[Q_BITS-1:0];
		return v[Q_BITS+1] ? Q_MIN : Q_MAX;
	endfunction

	met_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	met_zsq u_zsq (
		.clk (clk),
		.zx  (zx_q),
		.zy  (zy_q),
		.sx  (sx),
		.sy  (sy),
		.xy  (xy)
	);

	// zero width behaves as one
	assign w_eff = (img_w_q == '0) ? DIM_BITS'(1) : img_w_q;
	assign num_x = coord_num(in_data.pixel_x, w_eff);
	assign num_y = coord_num(py_q, img_h_q);

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// squares are never negative, so their sum fits unsigned
	assign esc_sum  = {1'b0, sx[Q_BITS-2:0]} + {1'b0, sy[Q_BITS-2:0]};
	assign upd_stop = (esc_sum > ESC_LIMIT) || (count_q >= max_iter_q);
	assign upd_hit  = (count_q != '0) && (count_q < max_iter_q);
	assign re_sum   = {{2{sx[Q_BITS-1]}}, sx} - {{2{sy[Q_BITS-1]}}, sy}
		+ {{2{cx_q[Q_BITS-1]}}, cx_q};
	assign im_sum   = {xy[Q_BITS-1], xy, 1'b0} + {{2{cy_q[Q_BITS-1]}}, cy_q};
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign c_new    = quo_to_q(div_rsp.quotient, neg_q);

	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = DVD_BITS'({count_q, {INT_BITS{1'b0}}});
		div_req.divisor = max_iter_q;
		case (state_q)
			ST_IDLE: begin
				div_req.start = in_valid;
				div_req.dividend = coord_dvd(num_x);
				div_req.divisor = DVS_BITS'(w_eff);
			end
			ST_DIVX: begin
				div_req.start = div_rsp.done;
				div_req.dividend = coord_dvd(num_y);
				div_req.divisor = DVS_BITS'(w_eff);
			end
			ST_UPD: begin
				div_req.start = upd_stop && upd_hit;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIVX;
			ST_DIVX: if (div_rsp.done) state_d = ST_DIVY;
			ST_DIVY: if (div_rsp.done) state_d = ST_MUL;
			ST_MUL:  state_d = ST_TRN;
			ST_TRN:  state_d = ST_UPD;
			ST_UPD: begin
				if (!upd_stop)
					state_d = ST_MUL;
				else if (upd_hit)
					state_d = ST_DIVI;
				else
					state_d = ST_FIN;
			end
			ST_DIVI: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			img_w_q     <= DIM_BITS'(640);
			img_h_q     <= DIM_BITS'(480);
			max_iter_q  <= ITER_BITS'(256);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_IMAGE_WIDTH:  img_w_q    <= cfg_data[DIM_BITS-1:0];
					CFG_IMAGE_HEIGHT: img_h_q    <= cfg_data[DIM_BITS-1:0];
					CFG_MAX_ITER:     max_iter_q <= cfg_data[ITER_BITS-1:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_q  <= in_data.pixel_x;
			py_q  <= in_data.pixel_y;
			neg_q <= num_x[MAG_BITS];
		end
		if (state_q == ST_DIVX && div_rsp.done) begin
			cx_q  <= c_new;
			neg_q <= num_y[MAG_BITS];
		end
		if (state_q == ST_DIVY && div_rsp.done) begin
			cy_q    <= c_new;
			zx_q    <= '0;
			zy_q    <= '0;
			count_q <= '0;
		end
		if (state_q == ST_UPD) begin
			if (upd_stop) begin
				hit_q <= upd_hit;
				int_q <= '0;
			end else begin
				zx_q    <= sat_sum(re_sum);
				zy_q    <= sat_sum(im_sum);
				count_q <= count_q + ITER_BITS'(1);
			end
		end
		if (state_q == ST_DIVI && div_rsp.done)
			int_q <= div_rsp.quotient[INT_BITS-1:0];
		if (out_load) begin
			out_q.out_x        <= px_q;
			out_q.out_y        <= py_q;
			out_q.plotted      <= hit_q;
			out_q.escape_count <= count_q;
			out_q.intensity    <= int_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`MET_ASSERT_IMPL(a_idle_div_quiet, (state_q == ST_IDLE), !div_rsp.busy, "divider busy between pixels")
	`MET_ASSERT_IMPL(a_div_done_state, div_rsp.done, (state_q == ST_DIVX || state_q == ST_DIVY || state_q == ST_DIVI), "divider done outside a division step")
	`MET_ASSERT_NEXT(a_count_hold, (state_q == ST_MUL || state_q == ST_TRN), $stable(count_q), "count moved outside update")
	`MET_ASSERT_IMPL(a_dark_no_intensity, (out_valid && !out_data.plotted), (out_data.intensity == '0), "intensity on unplotted pixel")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import met_pkg::*;

	localparam longint Q_TOP  = (longint'(1) <<< (FRAC_BITS + 3)) - 1;
	localparam longint Q_BOT  = -Q_TOP - 1;
	localparam longint FOUR_Q = longint'(4) <<< FRAC_BITS;
	localparam int     HOLD_CYCLES = 3000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	pix_in_t                  in_data = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	pix_out_t                 out_data;

	// shadow of the block's registers, as the predictor sees them
	longint cur_w = 640;
	longint cur_h = 480;
	longint cur_iter = 256;

	pix_in_t  pixel_q[$];
	pix_out_t result_q[$];
	int       n_pushed = 0;
	int       n_acc = 0;
	int       rx_count = 0;
	int       err_cnt = 0;
	logic     in_taken = 1'b0;

	mandelbrot_escape_time_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_q(longint v);
		if (v > Q_TOP) return Q_TOP;
		if (v < Q_BOT) return Q_BOT;
		return v;
	endfunction

	// Q4.28 product, truncated toward zero, saturated
	function automatic longint fx_mul(longint a, longint b);
		longint unsigned ua, ub, mag;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		mag = (ua * ub) >> FRAC_BITS;
		if (mag > longint'(Q_TOP) + 1) mag = longint'(Q_TOP) + 1;
		if ((a < 0) != (b < 0)) return clamp_q(-longint'(mag));
		return (mag > Q_TOP) ? Q_TOP : longint'(mag);
	endfunction

	// num/den in Q4.28, toward zero, saturated
	function automatic longint map_axis(longint num, longint den);
		longint unsigned mag, quo;
		mag = (num < 0) ? -num : num;
		if ((mag / den) >= 8) return (num < 0) ? Q_BOT : Q_TOP;
		quo = (mag << FRAC_BITS) / den;
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic pix_out_t escape_time(pix_in_t pix);
		pix_out_t r;
		longint   w, cx, cy, zx, zy, sx, sy, xy;
		longint   n;
		logic     hit;
		w  = (cur_w == 0) ? 1 : cur_w;
		cx = map_axis(2 * (2 * longint'(pix.pixel_x) - w), w);
		cy = map_axis(2 * (2 * longint'(pix.pixel_y) - cur_h), w);
		zx = 0;
		zy = 0;
		n  = 0;
		forever begin
			sx = fx_mul(zx, zx);
			sy = fx_mul(zy, zy);
			if (sx + sy > FOUR_Q || n >= cur_iter) break;
			xy = fx_mul(zx, zy);
			zx = clamp_q(sx - sy + cx);
			zy = clamp_q(2 * xy + cy);
			n++;
		end
		hit = (n != 0) && (n < cur_iter);
		r.out_x        = pix.pixel_x;
		r.out_y        = pix.pixel_y;
		r.plotted      = hit;
		r.escape_count = ITER_BITS'(n);
		r.intensity    = hit ? INT_BITS'((n << 16) / cur_iter) : '0;
		return r;
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	// input side: predict on every accepted transaction
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			result_q.push_back(escape_time(in_data));
			n_acc++;
		end
	end

	// output side
	always @(posedge clk) begin
		pix_out_t want;
		if (out_valid && out_ready) begin
			rx_count++;
			if (result_q.size() == 0) begin
				$error("result for pixel (%0d,%0d) with none pending",
					out_data.out_x, out_data.out_y);
				err_cnt++;
			end else begin
				want = result_q.pop_front();
				check_field("out_x", want.out_x, out_data.out_x);
				check_field("out_y", want.out_y, out_data.out_y);
				check_field("plotted", want.plotted, out_data.plotted);
				check_field("escape_count", want.escape_count, out_data.escape_count);
				check_field("intensity", want.intensity, out_data.intensity);
			end
		end
	end

	// sender: bursts separated by random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				in_data <= pixel_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 8);
						2: gap_left = $urandom_range(9, 120);
						default: gap_left = $urandom_range(121, 400);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches at random, plus one long hold-off
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  mode = 0;
	int  mode_left = 0;
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && rx_count >= 60) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	task automatic push_pixel(int unsigned x, int unsigned y);
		pix_in_t p;
		p.pixel_x = COORD_BITS'(x);
		p.pixel_y = COORD_BITS'(y);
		pixel_q.push_back(p);
		n_pushed++;
	endtask

	// every pixel has been taken and every result has come back
	task automatic drain();
		while (!(n_acc == n_pushed && result_q.size() == 0))
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		case (idx)
			CFG_IMAGE_WIDTH:  cur_w = val & 13'h1fff;
			CFG_IMAGE_HEIGHT: cur_h = val & 13'h1fff;
			CFG_MAX_ITER:     cur_iter = val & 16'hffff;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int unsigned w, int unsigned h, int unsigned mi);
		drain();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_MAX_ITER, mi);
	endtask

	initial begin : stim
		int unsigned w, h, mi, xr, yr;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// reset settings 640x480, limit 256
		push_pixel(0, 0);
		push_pixel(4095, 4095);
		push_pixel(320, 240);
		push_pixel(0, 240);
		push_pixel(4095, 0);
		push_pixel(0, 4095);
		push_pixel(12'haaa, 12'h555);
		push_pixel(12'h555, 12'haaa);
		push_pixel(480, 100);
		push_pixel(100, 300);

		// zero limit: nothing iterates
		set_config(640, 480, 0);
		push_pixel(0, 0);
		push_pixel(320, 240);

		// zero width and height, far-off pixels saturate
		set_config(0, 0, 16);
		push_pixel(0, 0);
		push_pixel(1, 1);
		push_pixel(4095, 4095);

		set_config(4096, 4096, 1);
		push_pixel(2048, 2048);
		push_pixel(0, 0);
		push_pixel(4095, 4095);

		set_config(1, 1, 65535);
		push_pixel(0, 0);
		push_pixel(4095, 0);

		// c = 0 runs the full limit
		set_config(4, 4, 65535);
		push_pixel(2, 2);

		set_config(4096, 1, 2);
		push_pixel(1024, 0);
		push_pixel(3000, 1);

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 9))
				0: w = $urandom_range(1, 8);
				1, 2, 3, 4, 5, 6: w = $urandom_range(16, 1024);
				default: w = $urandom_range(1025, 4096);
			endcase
			h = ($urandom_range(0, 1) != 0) ? ((w * 3 / 4 == 0) ? 1 : w * 3 / 4)
				: $urandom_range(1, 4096);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: mi = $urandom_range(2, 40);
				7, 8: mi = $urandom_range(41, 256);
				default: mi = $urandom_range(0, 1);
			endcase
			set_config(w, h, mi);
			xr = (w > 4095) ? 4095 : w;
			yr = (h > 4095) ? 4095 : h;
			for (int k = 0; k < 150; k++) begin
				if ($urandom_range(0, 3) != 0)
					push_pixel($urandom_range(0, xr), $urandom_range(0, yr));
				else
					push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
			end
		end

		drain();
		repeat (1000) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
